[rtl/qrot_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion rotation package
// Word types, datapath widths and register codes shared by the block's files.
// ----------------------------------------------------------------------------
package qrot_pkg;

	// Width of one Q-format component.
	localparam int COMP_W  = 16;
	// First Hamilton product: sums of four 16 x 16 products.
	localparam int T_W     = 34;
	// Second Hamilton product: sums of four 34 x 16 products.
	localparam int P_W     = 52;
	// Squared norm of the rotation quaternion, unsigned.
	localparam int N_W     = 33;
	// Quotient bits formed by the divider, one per step.
	localparam int DIV_STEPS = 16;

	// Configuration register codes, in address order.
	typedef enum logic [1:0] {
		REG_ROT_W = 2'd0,
		REG_ROT_I = 2'd1,
		REG_ROT_J = 2'd2,
		REG_ROT_K = 2'd3
	} reg_idx_t;

	// Input word.
	typedef struct packed {
		logic signed [COMP_W-1:0] in_w;
		logic signed [COMP_W-1:0] in_i;
		logic signed [COMP_W-1:0] in_j;
		logic signed [COMP_W-1:0] in_k;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic signed [COMP_W-1:0] out_w;
		logic signed [COMP_W-1:0] out_i;
		logic signed [COMP_W-1:0] out_j;
		logic signed [COMP_W-1:0] out_k;
		logic                     saturated;
		logic                     zero_norm;
	} out_word_t;

endpackage

[rtl/qrot_ifs.sv]
// ----------------------------------------------------------------------------
// Quaternion rotation channels
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface qrot_in_if import qrot_pkg::*; ;
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qrot_out_if import qrot_pkg::*; ;
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/quaternion_rotate_unit.sv]
// ----------------------------------------------------------------------------
// Quaternion rotation unit
// Rotates each input quaternion v by the configured r, giving r*v*r^-1 in
// Q3.12 with a pipelined restoring divide by the squared norm of r.
// ----------------------------------------------------------------------------
//  channel    | direction | handshake              | payload
//  -----------+-----------+------------------------+--------------------------
//  item_in    | in        | valid/ready            | in_w, in_i, in_j, in_k
//  item_out   | out       | valid/ready            | out_w..out_k, flags
//  APB        | in        | psel/penable, pready=1 | rot_w..rot_k at 0,4,8,12
//
// One word enters per cycle while the pipeline advances; each word goes from
// acceptance to the result through the product and sum stages, the magnitude
// stage, sixteen divide steps (one quotient bit each) and the output register.
// The whole pipeline advances when the output register is empty or taken, so
// a stall holds every stage and loses or repeats nothing.
// Reset clears the valid bits and loads r with 1.0.
// ----------------------------------------------------------------------------
module quaternion_rotate_unit import qrot_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	qrot_in_if.sink            item_in,
	qrot_out_if.source         item_out
);

	localparam int NSTG = DIV_STEPS + 1;

	// Configuration registers.
	logic signed [COMP_W-1:0] rot_q [4];
	reg_idx_t                 widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= COMP_W'(1) << FRAC_BITS;
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			rot_q[3] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_ROT_W: rot_q[0] <= pwdata[COMP_W-1:0];
				REG_ROT_I: rot_q[1] <= pwdata[COMP_W-1:0];
				REG_ROT_J: rot_q[2] <= pwdata[COMP_W-1:0];
				REG_ROT_K: rot_q[3] <= pwdata[COMP_W-1:0];
				default:   ;
			endcase
		end
	end

	// Register read-back, sign-extended to the bus.
	always_comb begin
		unique case (widx)
			REG_ROT_W: prdata = 32'(rot_q[0]);
			REG_ROT_I: prdata = 32'(rot_q[1]);
			REG_ROT_J: prdata = 32'(rot_q[2]);
			REG_ROT_K: prdata = 32'(rot_q[3]);
			default:   prdata = '0;
		endcase
	end

	// Pipeline advance: every stage moves together.
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_out;
	logic dv_vld_s [NSTG];

	assign adv           = !vld_out || item_out.ready;
	assign item_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_out <= 1'b0;
			for (int s = 0; s < NSTG; s++) dv_vld_s[s] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= item_in.valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			dv_vld_s[0] <= vld_s4;
			for (int s = 1; s < NSTG; s++) dv_vld_s[s] <= dv_vld_s[s-1];
			vld_out     <= dv_vld_s[NSTG-1];
		end
	end

	// Stage 1: products r[a]*v[b] and the squares of r.
	logic signed [COMP_W-1:0]   vin [4];
	logic signed [2*COMP_W-1:0] m_s1 [4][4];
	logic signed [2*COMP_W-1:0] sq_s1 [4];
	logic signed [COMP_W-1:0]   r_s1 [4];

	assign vin[0] = item_in.data.in_w;
	assign vin[1] = item_in.data.in_i;
	assign vin[2] = item_in.data.in_j;
	assign vin[3] = item_in.data.in_k;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) m_s1[a][b] <= rot_q[a] * vin[b];
				sq_s1[a] <= rot_q[a] * rot_q[a];
				r_s1[a]  <= rot_q[a];
			end
		end
	end

	// Stage 2: t = r*v and the squared norm.
	logic signed [T_W-1:0]    t_s2 [4];
	logic [N_W-1:0]           norm_s2;
	logic signed [COMP_W-1:0] r_s2 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2[0] <= T_W'(m_s1[0][0]) - T_W'(m_s1[1][1]) - T_W'(m_s1[2][2])
				- T_W'(m_s1[3][3]);
			t_s2[1] <= T_W'(m_s1[0][1]) + T_W'(m_s1[1][0]) + T_W'(m_s1[2][3])
				- T_W'(m_s1[3][2]);
			t_s2[2] <= T_W'(m_s1[0][2]) + T_W'(m_s1[2][0]) + T_W'(m_s1[3][1])
				- T_W'(m_s1[1][3]);
			t_s2[3] <= T_W'(m_s1[0][3]) + T_W'(m_s1[3][0]) + T_W'(m_s1[1][2])
				- T_W'(m_s1[2][1]);
			norm_s2 <= N_W'(unsigned'(sq_s1[0])) + N_W'(unsigned'(sq_s1[1]))
				+ N_W'(unsigned'(sq_s1[2])) + N_W'(unsigned'(sq_s1[3]));
			for (int a = 0; a < 4; a++) r_s2[a] <= r_s1[a];
		end
	end

	// Stage 3: products t[a]*r[b]; the conjugate signs are applied in the sums.
	logic signed [T_W+COMP_W-1:0] n_s3 [4][4];
	logic [N_W-1:0]               norm_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 4; a++)
				for (int b = 0; b < 4; b++) n_s3[a][b] <= t_s2[a] * r_s2[b];
			norm_s3 <= norm_s2;
		end
	end

	// Stage 4: p = t * conj(r).
	logic signed [P_W-1:0] p_s4 [4];
	logic [N_W-1:0]        norm_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4[0] <= P_W'(n_s3[0][0]) + P_W'(n_s3[1][1]) + P_W'(n_s3[2][2])
				+ P_W'(n_s3[3][3]);
			p_s4[1] <= P_W'(n_s3[1][0]) - P_W'(n_s3[0][1]) + P_W'(n_s3[3][2])
				- P_W'(n_s3[2][3]);
			p_s4[2] <= P_W'(n_s3[2][0]) - P_W'(n_s3[0][2]) + P_W'(n_s3[1][3])
				- P_W'(n_s3[3][1]);
			p_s4[3] <= P_W'(n_s3[3][0]) - P_W'(n_s3[0][3]) + P_W'(n_s3[2][1])
				- P_W'(n_s3[1][2]);
			norm_s4 <= norm_s3;
		end
	end

	// Divider stages. Index 0 holds the magnitude and the overflow check;
	// step s then decides quotient bit DIV_STEPS-s.
	logic [P_W-1:0]       dv_rem_s [NSTG][4];
	logic [DIV_STEPS-1:0] dv_quo_s [NSTG][4];
	logic                 dv_neg_s [NSTG][4];
	logic                 dv_big_s [NSTG][4];
	logic [N_W-1:0]       dv_norm_s [NSTG];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				dv_neg_s[0][c] <= p_s4[c][P_W-1];
				dv_rem_s[0][c] <= p_s4[c][P_W-1] ? P_W'(-p_s4[c]) : P_W'(p_s4[c]);
				dv_big_s[0][c] <= (p_s4[c][P_W-1] ? P_W'(-p_s4[c]) : P_W'(p_s4[c]))
					>= (P_W'(norm_s4) << DIV_STEPS);
				dv_quo_s[0][c] <= '0;
			end
			dv_norm_s[0] <= norm_s4;
		end
	end

	for (genvar s = 1; s < NSTG; s++) begin : g_div
		localparam int BIT = DIV_STEPS - s;
		logic [P_W-1:0] trial;

		assign trial = P_W'(dv_norm_s[s-1]) << BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int c = 0; c < 4; c++) begin
					if (dv_rem_s[s-1][c] >= trial) begin
						dv_rem_s[s][c] <= dv_rem_s[s-1][c] - trial;
						dv_quo_s[s][c] <= dv_quo_s[s-1][c]
							| (DIV_STEPS'(1) << BIT);
					end else begin
						dv_rem_s[s][c] <= dv_rem_s[s-1][c];
						dv_quo_s[s][c] <= dv_quo_s[s-1][c];
					end
					dv_neg_s[s][c] <= dv_neg_s[s-1][c];
					dv_big_s[s][c] <= dv_big_s[s-1][c];
				end
				dv_norm_s[s] <= dv_norm_s[s-1];
			end
		end
	end

	// Output stage: sign, saturation and the zero-norm case.
	logic signed [COMP_W-1:0] res [4];
	logic                     clip [4];
	logic                     zn;
	logic [DIV_STEPS-1:0]     qf [4];
	out_word_t                out_q;

	assign zn = (dv_norm_s[NSTG-1] == '0);

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			qf[c] = dv_quo_s[NSTG-1][c];
			if (dv_neg_s[NSTG-1][c]) begin
				clip[c] = dv_big_s[NSTG-1][c] || (qf[c] > DIV_STEPS'(32768));
				res[c]  = clip[c] ? -16'sd32768 : signed'(COMP_W'(-qf[c]));
			end else begin
				clip[c] = dv_big_s[NSTG-1][c] || (qf[c] > DIV_STEPS'(32767));
				res[c]  = clip[c] ? 16'sd32767 : signed'(COMP_W'(qf[c]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_w     <= zn ? '0 : res[0];
			out_q.out_i     <= zn ? '0 : res[1];
			out_q.out_j     <= zn ? '0 : res[2];
			out_q.out_k     <= zn ? '0 : res[3];
			out_q.saturated <= !zn && (clip[0] || clip[1] || clip[2] || clip[3]);
			out_q.zero_norm <= zn;
		end
	end

	assign item_out.valid = vld_out;
	assign item_out.data  = out_q;

endmodule

[rtl/qrot_checker.sv]
// ----------------------------------------------------------------------------
// Quaternion rotation port checker
// Watches the top level's ports for handshake and result-flag consistency.
// ----------------------------------------------------------------------------
module qrot_checker import qrot_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// A stalled result word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// With the output register empty the block takes input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	// A zero norm result is all zeros and never saturated.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_norm |-> out_data.out_w == 0 &&
		out_data.out_i == 0 && out_data.out_j == 0 && out_data.out_k == 0 &&
		!out_data.saturated)
		else $error("zero norm result not cleared");

	// A saturated result carries at least one clipped component.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
		out_data.out_w == 16'sh7fff || out_data.out_w == -16'sh8000 ||
		out_data.out_i == 16'sh7fff || out_data.out_i == -16'sh8000 ||
		out_data.out_j == 16'sh7fff || out_data.out_j == -16'sh8000 ||
		out_data.out_k == 16'sh7fff || out_data.out_k == -16'sh8000)
		else $error("saturated flag without a clipped component");

endmodule

bind quaternion_rotate_unit qrot_checker u_qrot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (item_in.ready),
	.out_valid (item_out.valid),
	.out_ready (item_out.ready),
	.out_data  (item_out.data)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion rotation unit testbench
// Drives quaternion words through the valid/ready input with random gaps,
// predicts r*v*r^-1 for every accepted word from a mirror of the rotation
// registers, and checks each result word in order while the result side
// stalls at random. The rotation is rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import qrot_pkg::*;

	typedef longint quat_t [4];

	localparam int FRAC      = 12;
	localparam int DRAIN_CYC = 40;
	localparam int WD_LIMIT  = 20000;
	localparam int LONG_HOLD = 300;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	qrot_in_if  in_ch ();
	qrot_out_if out_ch ();

	quaternion_rotate_unit #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_in(in_ch), .item_out(out_ch)
	);

	// Words waiting to be sent, and results the block still owes.
	in_word_t  send_q [$];
	out_word_t rotated_q [$];
	logic signed [15:0] rot_reg [4];

	logic in_taken;
	int   in_gap, out_gap, hold_cnt;
	int   hold_req, hold_seen;
	int   mismatches, words_sent, words_seen, zn_seen, sat_seen, idle_cnt;

	// Clock, period 10 ns.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic quat_t hamilton(quat_t a, quat_t b);
		quat_t p;
		p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
		p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
		p[2] = a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3];
		p[3] = a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1];
		return p;
	endfunction

	// Expected rotation of one word by the current register contents.
	function automatic out_word_t rotate_predict(in_word_t x);
		quat_t     r, rc, v, t, p;
		longint    nrm, q;
		logic signed [15:0] comp [4];
		logic      sat;
		out_word_t o;
		for (int n = 0; n < 4; n++) begin
			r[n]  = longint'(rot_reg[n]);
			rc[n] = (n == 0) ? r[n] : -r[n];
		end
		v[0] = longint'($signed(x.in_w));
		v[1] = longint'($signed(x.in_i));
		v[2] = longint'($signed(x.in_j));
		v[3] = longint'($signed(x.in_k));
		nrm = r[0]*r[0] + r[1]*r[1] + r[2]*r[2] + r[3]*r[3];
		o = '0;
		if (nrm == 0) begin
			o.zero_norm = 1'b1;
			return o;
		end
		t = hamilton(r, v);
		p = hamilton(t, rc);
		sat = 1'b0;
		for (int n = 0; n < 4; n++) begin
			// Division of signed longints truncates toward zero.
			q = p[n] / nrm;
			if (q > 32767) begin
				q = 32767;
				sat = 1'b1;
			end else if (q < -32768) begin
				q = -32768;
				sat = 1'b1;
			end
			comp[n] = q[15:0];
		end
		o.out_w = comp[0];
		o.out_i = comp[1];
		o.out_j = comp[2];
		o.out_k = comp[3];
		o.saturated = sat;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [15:0] pick_comp();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			return 16'($urandom());
		else if (r < 8)
			return 16'($signed($urandom_range(8192)) - 4096);
		return (r == 8) ? 16'h7fff : 16'h8000;
	endfunction

	// Word driver: changes on the falling edge, holds a word until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				void'(send_q.pop_front());
				in_gap = pick_gap();
			end
			if (in_ch.valid && !in_taken) begin
				// Word still on offer: keep it stable.
			end else if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (send_q.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= send_q[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result side readiness, with random gaps and one requested long hold.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt  = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_gap = pick_gap();
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on input acceptance, compare on result acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			idle_cnt = 0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (psel && penable && pwrite && pready)
				rot_reg[paddr[3:2]] <= pwdata[15:0];
			if (in_ch.valid && in_ch.ready) begin
				rotated_q.push_back(rotate_predict(in_ch.data));
				words_sent++;
			end
			if (out_ch.valid && out_ch.ready) begin
				words_seen++;
				if (out_ch.data.zero_norm)
					zn_seen++;
				if (out_ch.data.saturated)
					sat_seen++;
				if (rotated_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", out_ch.data);
				end else begin
					out_word_t e;
					e = rotated_q.pop_front();
					if (out_ch.data !== e) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp w=%0d i=%0d j=%0d k=%0d sat=%b zn=%b",
								e.out_w, e.out_i, e.out_j, e.out_k, e.saturated,
								e.zero_norm);
							$display("          got w=%0d i=%0d j=%0d k=%0d sat=%b zn=%b",
								out_ch.data.out_w, out_ch.data.out_i,
								out_ch.data.out_j, out_ch.data.out_k,
								out_ch.data.saturated, out_ch.data.zero_norm);
						end
					end
				end
			end
			// Watchdog over cycles with work outstanding but no progress.
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(send_q.size() == 0 && rotated_q.size() == 0))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= WD_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", rotated_q.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{16{val[15]}}, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_rotation(input logic [15:0] w, input logic [15:0] i,
		input logic [15:0] j, input logic [15:0] k);
		apb_write(REG_ROT_W, w);
		apb_write(REG_ROT_I, i);
		apb_write(REG_ROT_J, j);
		apb_write(REG_ROT_K, k);
	endtask

	task automatic push_word(input logic [15:0] w, input logic [15:0] i,
		input logic [15:0] j, input logic [15:0] k);
		in_word_t x;
		x.in_w = w;
		x.in_i = i;
		x.in_j = j;
		x.in_k = k;
		send_q.push_back(x);
	endtask

	// Wait until every word is sent and every result is in, then let the
	// pipeline settle before the registers change.
	task automatic drain();
		while (send_q.size() > 0 || rotated_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic random_words(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(3) != 0)
				push_word(16'h0, pick_comp(), pick_comp(), pick_comp());
			else
				push_word(pick_comp(), pick_comp(), pick_comp(), pick_comp());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		in_gap = 0;
		out_gap = 0;
		hold_cnt = 0;
		hold_req = 0;
		hold_seen = 0;
		mismatches = 0;
		words_sent = 0;
		words_seen = 0;
		zn_seen = 0;
		sat_seen = 0;
		rot_reg[0] = 16'sd4096;
		rot_reg[1] = '0;
		rot_reg[2] = '0;
		rot_reg[3] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under the reset rotation (identity).
		push_word(16'h0, 16'h0, 16'h0, 16'h0);
		push_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		push_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_word(16'h0, 16'h7fff, 16'h8000, 16'h1000);
		push_word(16'hffff, 16'h0001, 16'hffff, 16'h0001);
		push_word(16'h1000, 16'h0, 16'h0, 16'h0);
		drain();

		// Quarter turn about k, then a large vector that grows past 16 bits.
		set_rotation(16'd2896, 16'd0, 16'd0, 16'd2896);
		push_word(16'h0, 16'h1000, 16'h0, 16'h0);
		push_word(16'h0, 16'h7fff, 16'h8000, 16'h7fff);
		push_word(16'h8000, 16'h8000, 16'h7fff, 16'h0);
		drain();
		set_rotation(16'd4096, 16'd4096, 16'd4096, 16'd0);
		push_word(16'h0, 16'h7fff, 16'h7fff, 16'h7fff);
		push_word(16'h0, 16'h8000, 16'h8000, 16'h8000);
		drain();

		// Zero norm rotation.
		set_rotation(16'h0, 16'h0, 16'h0, 16'h0);
		push_word(16'h0, 16'h1234, 16'h8000, 16'h7fff);
		push_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		random_words(20);
		drain();

		// Register extremes.
		set_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		push_word(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		random_words(100);
		drain();
		set_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		random_words(100);
		drain();
		set_rotation(16'h0, 16'h0, 16'h0, 16'h1);
		random_words(100);
		drain();
		set_rotation(16'h8000, 16'h7fff, 16'h0, 16'h8000);
		random_words(100);
		// Long result-side hold while words keep coming.
		hold_req++;
		drain();

		// Random rotations for the remainder of the run.
		for (int ph = 0; ph < 11; ph++) begin
			set_rotation(pick_comp(), pick_comp(), pick_comp(), pick_comp());
			random_words(120);
			drain();
		end

		$display("sent %0d words over %0d rotation settings, %0d results checked",
			words_sent, 19, words_seen);
		$display("zero norm results %0d, saturated results %0d, mismatches %0d",
			zn_seen, sat_seen, mismatches);
		if (mismatches == 0 && rotated_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
rtl/qrot_pkg.sv
rtl/qrot_ifs.sv
rtl/quaternion_rotate_unit.sv
rtl/qrot_checker.sv
verif/tb_top.sv
